FILE: rtl/assert_macros.svh
// Assertion macros for the pattern sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LMPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmps: same-cycle implication failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define LMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmps: next-cycle implication failed");

`endif

FILE: rtl/lmps_pkg.sv
// Types, constants and helper functions of the LED matrix pattern sequencer.
package lmps_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int MAX_DIM     = 64;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);

    localparam int DIM_W   = 7;
    localparam int AREA_W  = 13;
    localparam int STEP_W  = 13;
    localparam int PAUSE_W = 16;
    localparam int CUR_W   = 5;
    localparam int FUNC_W  = 8;
    localparam int PARAM_W = 8;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int PN_W    = 4;
    localparam int CFG_W   = 3;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_QUERY = 2'd1,
        OP_WRITE = 2'd2,
        OP_FIRE  = 2'd3
    } t_opcode;

    localparam logic [CFG_W-1:0] CFG_ROWS     = 3'd0;
    localparam logic [CFG_W-1:0] CFG_COLS     = 3'd1;
    localparam logic [CFG_W-1:0] CFG_COUNT    = 3'd2;
    localparam logic [CFG_W-1:0] CFG_REPEAT   = 3'd3;
    localparam logic [CFG_W-1:0] CFG_SINGLE   = 3'd4;
    localparam logic [CFG_W-1:0] CFG_DRAW_OFF = 3'd5;

    localparam logic [FUNC_W-1:0] FN_BLANK        = 8'd0;
    localparam logic [FUNC_W-1:0] FN_BAR          = 8'd1;
    localparam logic [FUNC_W-1:0] FN_BAR_REV      = 8'd2;
    localparam logic [FUNC_W-1:0] FN_FILL_REV     = 8'd3;
    localparam logic [FUNC_W-1:0] FN_FILL         = 8'd4;
    localparam logic [FUNC_W-1:0] FN_BAR_BOTH     = 8'd5;
    localparam logic [FUNC_W-1:0] FN_BLINK        = 8'd6;
    localparam logic [FUNC_W-1:0] FN_BLINK_ROW    = 8'd7;
    localparam logic [FUNC_W-1:0] FN_WIPE_REV     = 8'd8;
    localparam logic [FUNC_W-1:0] FN_WIPE         = 8'd9;
    localparam logic [FUNC_W-1:0] FN_COL_SCAN     = 8'd10;
    localparam logic [FUNC_W-1:0] FN_COL_SCAN_REV = 8'd11;
    localparam logic [FUNC_W-1:0] FN_ROW_SCAN     = 8'd12;
    localparam logic [FUNC_W-1:0] FN_ROW_SCAN_REV = 8'd13;
    localparam logic [FUNC_W-1:0] FN_BOX_IN       = 8'd14;
    localparam logic [FUNC_W-1:0] FN_BOX_OUT      = 8'd15;
    localparam logic [FUNC_W-1:0] FN_DIAG         = 8'd16;
    localparam logic [FUNC_W-1:0] FN_RING         = 8'd80;

    localparam logic [PARAM_W-1:0] DIAG_SE = 8'd0;
    localparam logic [PARAM_W-1:0] DIAG_SW = 8'd1;
    localparam logic [PARAM_W-1:0] DIAG_NE = 8'd2;
    localparam logic [PARAM_W-1:0] DIAG_NW = 8'd3;

    typedef struct packed {
        logic [PARAM_W-1:0] param;
        logic [PAUSE_W-1:0] pause;
        logic [FUNC_W-1:0]  func;
    } t_entry;

    typedef struct packed {
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  cols;
        logic [AREA_W-1:0] area;
        logic [CUR_W-1:0]  count;
        logic              repeat_seq;
        logic              single;
        logic              draw_off;
    } t_cfg;

    // State after the item's action, plus the query coordinates.
    typedef struct packed {
        t_opcode            op;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [STEP_W-1:0]  step;
        logic [CUR_W-1:0]   cur;
        logic [FUNC_W-1:0]  func;
        logic [PARAM_W-1:0] param;
    } t_s1;

    typedef struct packed {
        t_opcode            op;
        logic               playing;
        logic               in_area;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [STEP_W-1:0]  step;
        logic [CUR_W-1:0]   cur;
        logic [FUNC_W-1:0]  func;
        logic [PARAM_W-1:0] param;
        logic [12:0]        pix;
        logic signed [15:0] last;
        logic [13:0]        dist_sq;
        logic [25:0]        s_sq;
        logic [27:0]        sp_sq;
    } t_s2;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Steps in one pass of a pattern.
    function automatic logic [STEP_W-1:0] patt_len(
        input logic [FUNC_W-1:0]  func,
        input logic [PARAM_W-1:0] param,
        input logic [DIM_W-1:0]   rows,
        input logic [DIM_W-1:0]   cols,
        input logic [AREA_W-1:0]  area
    );
        logic [DIM_W:0]      rc_sum;
        logic [STEP_W-1:0]   res;
        rc_sum = {1'b0, rows} + {1'b0, cols};
        unique case (func)
            FN_BAR, FN_BAR_REV, FN_FILL_REV, FN_FILL, FN_BAR_BOTH,
            FN_WIPE_REV, FN_WIPE:             res = STEP_W'(area);
            FN_BLINK, FN_BLINK_ROW:           res = STEP_W'(param);
            FN_COL_SCAN, FN_COL_SCAN_REV:     res = STEP_W'(cols);
            FN_ROW_SCAN, FN_ROW_SCAN_REV:     res = STEP_W'(rows);
            FN_BOX_IN, FN_BOX_OUT:            res = STEP_W'(cols >> 1);
            FN_DIAG:                          res = STEP_W'(rc_sum);
            FN_RING:                          res = STEP_W'(rc_sum >> 2);
            default:                          res = STEP_W'(1);
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/lmps_seq.sv
// Sequencer state: configuration, pattern table, counters and the first stage register.
module lmps_seq import lmps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_index,
    input  logic [DIM_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    input  logic [1:0]         i_opcode,
    input  logic [ROW_W-1:0]   i_pixel_row,
    input  logic [COL_W-1:0]   i_pixel_col,
    input  logic [PN_W-1:0]    i_pattern_number,
    input  logic [FUNC_W-1:0]  i_func_code,
    input  logic [PAUSE_W-1:0] i_step_pause,
    input  logic [PARAM_W-1:0] i_pattern_param,
    input  logic               i_down_ready,
    output logic               o_in_stall,
    output t_cfg               o_cfg,
    output logic               o_s1_valid,
    output t_s1                o_s1
);

    t_entry             r_table [TABLE_DEPTH];
    t_entry             r_entry;
    t_entry             n_entry;
    t_entry             wr_data;
    logic [STEP_W-1:0]  r_step,  n_step;
    logic [PAUSE_W-1:0] r_pause, n_pause;
    logic [CUR_W-1:0]   r_cur,   n_cur;
    logic [DIM_W-1:0]   r_rows, r_cols;
    logic [AREA_W-1:0]  r_area;
    logic [CUR_W-1:0]   r_count;
    logic               r_repeat, r_single, r_draw_off;
    logic               r_s1_valid;
    t_s1                r_s1;

    t_opcode            op;
    logic               rdy;
    logic               accept;
    logic               wr_en;
    logic               wr_hit;
    logic               cfg_single_wr;
    logic               playing_now;
    logic [STEP_W-1:0]  cur_len;
    logic [PAUSE_W:0]   pause_inc;
    logic [STEP_W:0]    step_inc;
    logic [CUR_W-1:0]   cur_inc;
    logic [DIM_W-1:0]   cfg_dim;
    logic [13:0]        area_new_rows;
    logic [13:0]        area_new_cols;

    assign op     = t_opcode'(i_opcode);
    assign rdy    = !r_s1_valid || i_down_ready;
    assign accept = i_in_valid && rdy;

    assign cfg_dim       = clamp_dim(i_cfg_data);
    assign area_new_rows = {7'b0, cfg_dim} * {7'b0, r_cols};
    assign area_new_cols = {7'b0, r_rows} * {7'b0, cfg_dim};
    assign cfg_single_wr = i_cfg_we && (i_cfg_index == CFG_SINGLE);

    always_comb begin
        cur_len     = patt_len(r_entry.func, r_entry.param, r_rows, r_cols, r_area);
        playing_now = (r_cur < r_count) && !(r_single && (r_step >= cur_len));
        pause_inc   = {1'b0, r_pause} + 17'd1;
        step_inc    = {1'b0, r_step} + 14'd1;
        cur_inc     = r_cur + 5'd1;
        wr_data     = '{param: i_pattern_param, pause: i_step_pause, func: i_func_code};
        wr_en       = accept && (op == OP_WRITE) && (32'(i_pattern_number) < TABLE_DEPTH);
        wr_hit      = wr_en && ({1'b0, i_pattern_number} == r_cur);

        n_step  = r_step;
        n_pause = r_pause;
        n_cur   = r_cur;

        if (accept) begin
            unique case (op)
                OP_TICK: begin
                    if (playing_now) begin
                        if (pause_inc < {1'b0, r_entry.pause}) begin
                            n_pause = pause_inc[PAUSE_W-1:0];
                        end else begin
                            n_pause = '0;
                            if (step_inc >= {1'b0, cur_len}) begin
                                // past the last step: step past the end in single mode, else next pattern
                                if (r_single) begin
                                    n_step = step_inc[STEP_W-1:0];
                                end else begin
                                    n_step = '0;
                                    n_cur  = (cur_inc >= r_count && r_repeat) ? '0 : cur_inc;
                                end
                            end else begin
                                n_step = step_inc[STEP_W-1:0];
                            end
                        end
                    end
                end
                OP_QUERY, OP_WRITE: begin
                end
                OP_FIRE: begin
                    if ({1'b0, i_pattern_number} < r_count) begin
                        n_cur   = {1'b0, i_pattern_number};
                        n_step  = '0;
                        n_pause = '0;
                    end
                end
            endcase
        end

        if (cfg_single_wr) begin
            if (i_cfg_data[0]) begin
                n_cur = '0;
            end else begin
                n_step  = '0;
                n_pause = '0;
            end
        end

        // entry of the pattern that is current after this cycle
        if (wr_hit) begin
            n_entry = wr_data;
        end else if (32'(n_cur) < TABLE_DEPTH) begin
            n_entry = r_table[TBL_AW'(n_cur)];
        end else begin
            n_entry = '0;
        end

        // entering single mode parks the counter at the end of pattern 0
        if (cfg_single_wr && i_cfg_data[0]) begin
            n_step = patt_len(n_entry.func, n_entry.param, r_rows, r_cols, r_area);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= '0;
            r_pause    <= '0;
            r_cur      <= '0;
            r_rows     <= DIM_W'(8);
            r_cols     <= DIM_W'(8);
            r_area     <= AREA_W'(64);
            r_count    <= '0;
            r_repeat   <= 1'b0;
            r_single   <= 1'b0;
            r_draw_off <= 1'b1;
            r_s1_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_pause <= n_pause;
            r_cur   <= n_cur;
            if (rdy) begin
                r_s1_valid <= i_in_valid;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ROWS: begin
                        r_rows <= cfg_dim;
                        r_area <= area_new_rows[AREA_W-1:0];
                    end
                    CFG_COLS: begin
                        r_cols <= cfg_dim;
                        r_area <= area_new_cols[AREA_W-1:0];
                    end
                    CFG_COUNT: begin
                        r_count <= (32'(i_cfg_data[CUR_W-1:0]) > TABLE_DEPTH) ?
                                   CUR_W'(TABLE_DEPTH) : i_cfg_data[CUR_W-1:0];
                    end
                    CFG_REPEAT:   r_repeat   <= i_cfg_data[0];
                    CFG_SINGLE:   r_single   <= i_cfg_data[0];
                    CFG_DRAW_OFF: r_draw_off <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[TBL_AW'(i_pattern_number)] <= wr_data;
        end
        r_entry <= n_entry;
        if (rdy) begin
            r_s1 <= '{op: op, row: i_pixel_row, col: i_pixel_col, step: n_step,
                      cur: n_cur, func: n_entry.func, param: n_entry.param};
        end
    end

    assign o_in_stall = !rdy;
    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;
    assign o_cfg      = '{rows: r_rows, cols: r_cols, area: r_area, count: r_count,
                          repeat_seq: r_repeat, single: r_single, draw_off: r_draw_off};

endmodule

FILE: rtl/lmps_prep.sv
// Second stage: play status, pixel index and the squares for the ring test.
module lmps_prep import lmps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_s1_valid,
    input  t_s1  i_s1,
    input  logic i_down_ready,
    output logic o_ready,
    output logic o_s2_valid,
    output t_s2  o_s2
);

    logic               r_s2_valid;
    t_s2                r_s2;
    t_s2                n_s2;
    logic               rdy;
    logic [STEP_W-1:0]  len;
    logic [12:0]        pix;
    logic [STEP_W:0]    sp;
    logic signed [7:0]  rx, ry;
    logic signed [15:0] rx_w, ry_w;
    logic signed [15:0] rx_sq, ry_sq;

    assign rdy = !r_s2_valid || i_down_ready;

    always_comb begin
        len   = patt_len(i_s1.func, i_s1.param, i_cfg.rows, i_cfg.cols, i_cfg.area);
        pix   = {7'b0, i_s1.row} * {6'b0, i_cfg.cols} + {7'b0, i_s1.col};
        sp    = {1'b0, i_s1.step} + {6'b0, i_s1.param};
        // ring offsets from the center of the area
        rx    = signed'({2'b0, i_cfg.cols[DIM_W-1:1]}) - signed'({2'b0, i_s1.col});
        ry    = signed'({2'b0, i_cfg.rows[DIM_W-1:1]}) - signed'({2'b0, i_s1.row});
        rx_w  = 16'(rx);
        ry_w  = 16'(ry);
        rx_sq = rx_w * rx_w;
        ry_sq = ry_w * ry_w;

        n_s2.op      = i_s1.op;
        n_s2.playing = (i_s1.cur < i_cfg.count) && !(i_cfg.single && (i_s1.step >= len));
        n_s2.in_area = ({1'b0, i_s1.row} < i_cfg.rows) && ({1'b0, i_s1.col} < i_cfg.cols);
        n_s2.row     = i_s1.row;
        n_s2.col     = i_s1.col;
        n_s2.step    = i_s1.step;
        n_s2.cur     = i_s1.cur;
        n_s2.func    = i_s1.func;
        n_s2.param   = i_s1.param;
        n_s2.pix     = pix;
        n_s2.last    = signed'({3'b0, i_cfg.area}) - 16'sd1 - signed'({3'b0, i_s1.step});
        n_s2.dist_sq = {1'b0, rx_sq[12:0]} + {1'b0, ry_sq[12:0]};
        n_s2.s_sq    = {13'b0, i_s1.step} * {13'b0, i_s1.step};
        n_s2.sp_sq   = {14'b0, sp} * {14'b0, sp};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (rdy) begin
            r_s2_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy) begin
            r_s2 <= n_s2;
        end
    end

    assign o_ready    = rdy;
    assign o_s2_valid = r_s2_valid;
    assign o_s2       = r_s2;

endmodule

FILE: rtl/lmps_eval.sv
// Last stage: light test for each pattern function and the result register.
module lmps_eval import lmps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_s2_valid,
    input  t_s2                i_s2,
    input  logic               i_out_stall,
    output logic               o_ready,
    output logic               o_out_valid,
    output logic               o_light_on,
    output logic               o_write_enable,
    output logic               o_playing,
    output logic [STEP_W-1:0]  o_step_number,
    output logic [CUR_W-1:0]   o_pattern_index
);

    logic               r_out_valid;
    logic               r_light_on,  n_light_on;
    logic               r_write_en,  n_write_en;
    logic               r_playing;
    logic [STEP_W-1:0]  r_step;
    logic [CUR_W-1:0]   r_cur;
    logic               rdy;

    logic signed [15:0] s, pix, p, r, c, t, rows, cols, rows_half, cols_half;
    logic signed [15:0] cmax_in, rmax_in, cmax_out, cmin_out, rmax_out, rmin_out;
    logic [29:0]        dist30, lo30, hi30;
    logic               bar_fwd, bar_rev, box_in, box_out, diag, ring;
    logic               light, query_ok;

    assign rdy = !r_out_valid || !i_out_stall;

    always_comb begin
        s         = signed'({3'b0, i_s2.step});
        pix       = signed'({3'b0, i_s2.pix});
        p         = signed'({8'b0, i_s2.param});
        r         = signed'({10'b0, i_s2.row});
        c         = signed'({10'b0, i_s2.col});
        t         = signed'(i_s2.last);
        rows      = signed'({9'b0, i_cfg.rows});
        cols      = signed'({9'b0, i_cfg.cols});
        rows_half = signed'({10'b0, i_cfg.rows[DIM_W-1:1]});
        cols_half = signed'({10'b0, i_cfg.cols[DIM_W-1:1]});

        bar_fwd = (pix >= s) && (pix < s + p);
        bar_rev = (pix <= t) && (pix + p > t);

        // shrinking frame
        cmax_in = cols - 16'sd1 - s;
        rmax_in = rows - 16'sd1 - s;
        box_in  = (((r == s) || (r == rmax_in)) && (c >= s) && (c <= cmax_in)) ||
                  (((c == s) || (c == cmax_in)) && (r >= s) && (r <= rmax_in));

        // growing frame from the center
        cmax_out = cols_half + s;
        cmin_out = cols - 16'sd1 - cmax_out;
        rmax_out = rows_half + s;
        rmin_out = rows - 16'sd1 - rmax_out;
        box_out  = (((r == rmin_out) || (r == rmax_out)) && (c >= cmin_out) &&
                    (c <= cmax_out)) ||
                   (((c == cmin_out) || (c == cmax_out)) && (r >= rmin_out) &&
                    (r <= rmax_out));

        unique case (i_s2.param)
            DIAG_SE: diag = (s >= r) && (c == s - r);
            DIAG_SW: diag = (c == cols - 16'sd1 - s + rows - 16'sd1 - r);
            DIAG_NE: diag = (c == cols - 16'sd1 - s + r);
            DIAG_NW: diag = (c == s + r - rows - 16'sd1);
            default: diag = 1'b0;
        endcase

        // radius test at four times scale: 4*s^2 <= d < 4*(s+p)^2
        dist30 = {16'b0, i_s2.dist_sq};
        lo30   = {2'b0, i_s2.s_sq, 2'b00};
        hi30   = {i_s2.sp_sq, 2'b00};
        ring   = (dist30 >= lo30) && (dist30 < hi30);

        unique case (i_s2.func)
            FN_BAR:          light = bar_fwd;
            FN_BAR_REV:      light = bar_rev;
            FN_FILL_REV:     light = pix >= t;
            FN_FILL:         light = pix <= s;
            FN_BAR_BOTH:     light = bar_fwd || bar_rev;
            FN_BLINK:        light = pix[0] ^ s[0];
            FN_BLINK_ROW:    light = pix[0] ^ r[0] ^ s[0];
            FN_WIPE_REV:     light = pix < t;
            FN_WIPE:         light = pix > s;
            FN_COL_SCAN:     light = s == c;
            FN_COL_SCAN_REV: light = s == cols - 16'sd1 - c;
            FN_ROW_SCAN:     light = s == r;
            FN_ROW_SCAN_REV: light = s == rows - 16'sd1 - r;
            FN_BOX_IN:       light = box_in;
            FN_BOX_OUT:      light = box_out;
            FN_DIAG:         light = diag;
            FN_RING:         light = ring;
            default:         light = 1'b0;
        endcase

        query_ok   = (i_s2.op == OP_QUERY) && i_s2.playing && i_s2.in_area;
        n_light_on = query_ok && light;
        n_write_en = query_ok && (light || i_cfg.draw_off);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rdy) begin
            r_out_valid <= i_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy) begin
            r_light_on <= n_light_on;
            r_write_en <= n_write_en;
            r_playing  <= i_s2.playing;
            r_step     <= i_s2.step;
            r_cur      <= i_s2.cur;
        end
    end

    assign o_ready         = rdy;
    assign o_out_valid     = r_out_valid;
    assign o_light_on      = r_light_on;
    assign o_write_enable  = r_write_en;
    assign o_playing       = r_playing;
    assign o_step_number   = r_step;
    assign o_pattern_index = r_cur;

endmodule

FILE: rtl/led_matrix_pattern_sequencer_core.sv
// Top level of the LED matrix pattern sequencer.
// Takes one item per clock while the input is not stalled and returns one result per item.
// The item passes three register stages: counters and table entry, then pixel index and
// squares, then the per-function compares and the result. Ticks and fires update the
// counters, and table writes the table, at the transfer edge itself, so a following item
// sees the new state in the next clock. The result carries the play state after the item's
// action. The 16-entry pattern table has no reset: write an entry before playing it.
// Configuration writes belong to idle time, when no result is outstanding. Each stage
// advances when the one after it is free. While the output stalls, up to three items sit in
// the pipe before the input stalls.
module led_matrix_pattern_sequencer_core import lmps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_index,
    input  logic [DIM_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [ROW_W-1:0]   i_pixel_row,
    input  logic [COL_W-1:0]   i_pixel_col,
    input  logic [PN_W-1:0]    i_pattern_number,
    input  logic [FUNC_W-1:0]  i_func_code,
    input  logic [PAUSE_W-1:0] i_step_pause,
    input  logic [PARAM_W-1:0] i_pattern_param,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_light_on,
    output logic               o_write_enable,
    output logic               o_playing,
    output logic [STEP_W-1:0]  o_step_number,
    output logic [CUR_W-1:0]   o_pattern_index
);

`include "assert_macros.svh"

    t_cfg cfg;
    logic s1_valid;
    t_s1  s1;
    logic s2_valid;
    t_s2  s2;
    logic prep_ready;
    logic eval_ready;

    lmps_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_opcode         (i_opcode),
        .i_pixel_row      (i_pixel_row),
        .i_pixel_col      (i_pixel_col),
        .i_pattern_number (i_pattern_number),
        .i_func_code      (i_func_code),
        .i_step_pause     (i_step_pause),
        .i_pattern_param  (i_pattern_param),
        .i_down_ready     (prep_ready),
        .o_in_stall       (o_in_stall),
        .o_cfg            (cfg),
        .o_s1_valid       (s1_valid),
        .o_s1             (s1)
    );

    lmps_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_s1_valid   (s1_valid),
        .i_s1         (s1),
        .i_down_ready (eval_ready),
        .o_ready      (prep_ready),
        .o_s2_valid   (s2_valid),
        .o_s2         (s2)
    );

    lmps_eval u_eval (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_s2_valid      (s2_valid),
        .i_s2            (s2),
        .i_out_stall     (i_out_stall),
        .o_ready         (eval_ready),
        .o_out_valid     (o_out_valid),
        .o_light_on      (o_light_on),
        .o_write_enable  (o_write_enable),
        .o_playing       (o_playing),
        .o_step_number   (o_step_number),
        .o_pattern_index (o_pattern_index)
    );

    // a lit light is always written, and only while a pattern plays
    `LMPS_ASSERT_IMPLY(a_lit_is_written, i_clk, i_rst_n, o_out_valid && o_light_on, o_write_enable)
    `LMPS_ASSERT_IMPLY(a_lit_needs_play, i_clk, i_rst_n, o_out_valid && o_light_on, o_playing)
    `LMPS_ASSERT_IMPLY(a_play_in_range, i_clk, i_rst_n, o_out_valid && o_playing, o_pattern_index < cfg.count)
    // every input transfer lands in the first stage
    `LMPS_ASSERT_NEXT(a_transfer_loads, i_clk, i_rst_n, i_in_valid && !o_in_stall, s1_valid)

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the LED matrix pattern sequencer core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lmps_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 90;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct {
        logic              light_on;
        logic              write_enable;
        logic              playing;
        logic [STEP_W-1:0] step;
        logic [CUR_W-1:0]  pattern_idx;
    } t_light_result;

    class light_scoreboard;
        t_entry        entries [TABLE_DEPTH];
        int unsigned   step_cnt;
        int unsigned   pause_cnt;
        int unsigned   cur_pat;
        int unsigned   rows_reg;
        int unsigned   cols_reg;
        int unsigned   count_reg;
        bit            repeat_on;
        bit            single_on;
        bit            draw_off_on;
        t_light_result expected_q [$];
        int unsigned   errors;

        function new();
            foreach (entries[i]) entries[i] = '0;
            step_cnt    = 0;
            pause_cnt   = 0;
            cur_pat     = 0;
            rows_reg    = 8;
            cols_reg    = 8;
            count_reg   = 0;
            repeat_on   = 0;
            single_on   = 0;
            draw_off_on = 1;
            errors      = 0;
        endfunction

        function int unsigned bounded_dim(int unsigned v);
            if (v < 1) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return v;
        endfunction

        function int unsigned active_count();
            if (count_reg > TABLE_DEPTH) return TABLE_DEPTH;
            return count_reg;
        endfunction

        function t_entry entry_now();
            t_entry e;
            if (cur_pat < TABLE_DEPTH) begin
                e = entries[cur_pat];
            end else begin
                e = '0;
            end
            return e;
        endfunction

        function int unsigned steps_in_pattern();
            t_entry      e;
            int unsigned rows;
            int unsigned cols;
            e    = entry_now();
            rows = bounded_dim(rows_reg);
            cols = bounded_dim(cols_reg);
            case (e.func)
                FN_BLANK: return 1;
                FN_BAR, FN_BAR_REV, FN_FILL_REV, FN_FILL, FN_BAR_BOTH,
                FN_WIPE_REV, FN_WIPE: return rows * cols;
                FN_BLINK, FN_BLINK_ROW: return e.param;
                FN_COL_SCAN, FN_COL_SCAN_REV: return cols;
                FN_ROW_SCAN, FN_ROW_SCAN_REV: return rows;
                FN_BOX_IN, FN_BOX_OUT: return cols / 2;
                FN_DIAG: return rows + cols;
                FN_RING: return (rows + cols) / 4;
                default: return 1;
            endcase
        endfunction

        function bit is_running();
            if (cur_pat >= active_count()) return 0;
            if (single_on && step_cnt >= steps_in_pattern()) return 0;
            return 1;
        endfunction

        function bit light_is_on(int r, int c);
            t_entry e;
            int     p;
            int     rows;
            int     cols;
            int     s;
            int     n;
            int     t;
            int     cmin;
            int     cmax;
            int     rmin;
            int     rmax;
            longint dx;
            longint dy;
            longint d_sq;
            longint lo;
            longint hi;
            e    = entry_now();
            p    = int'(e.param);
            rows = int'(bounded_dim(rows_reg));
            cols = int'(bounded_dim(cols_reg));
            s    = int'(step_cnt);
            n    = r * cols + c;
            t    = rows * cols - 1 - s;
            case (e.func)
                FN_BAR:          return n >= s && n < s + p;
                FN_BAR_REV:      return n <= t && n + p > t;
                FN_FILL_REV:     return n >= t;
                FN_FILL:         return n <= s;
                FN_BAR_BOTH:     return (n >= s && n < s + p) || (n <= t && n + p > t);
                FN_BLINK:        return ((n + s) & 1) != 0;
                FN_BLINK_ROW:    return ((n + r + s) & 1) != 0;
                FN_WIPE_REV:     return n < t;
                FN_WIPE:         return n > s;
                FN_COL_SCAN:     return s == c;
                FN_COL_SCAN_REV: return s == cols - 1 - c;
                FN_ROW_SCAN:     return s == r;
                FN_ROW_SCAN_REV: return s == rows - 1 - r;
                FN_BOX_IN: begin
                    cmax = cols - 1 - s;
                    rmax = rows - 1 - s;
                    return ((r == s || r == rmax) && c >= s && c <= cmax) ||
                           ((c == s || c == cmax) && r >= s && r <= rmax);
                end
                FN_BOX_OUT: begin
                    cmax = cols / 2 + s;
                    cmin = cols - 1 - cmax;
                    rmax = rows / 2 + s;
                    rmin = rows - 1 - rmax;
                    return ((r == rmin || r == rmax) && c >= cmin && c <= cmax) ||
                           ((c == cmin || c == cmax) && r >= rmin && r <= rmax);
                end
                FN_DIAG: begin
                    if (e.param == DIAG_SE) return s >= r && c == s - r;
                    if (e.param == DIAG_SW) return c == cols - 1 - s + rows - 1 - r;
                    if (e.param == DIAG_NE) return c == cols - 1 - s + r;
                    if (e.param == DIAG_NW) return c == s + r - rows - 1;
                    return 0;
                end
                FN_RING: begin
                    // radius test at 4x scale, kept in exact integers
                    dy   = rows / 2 - r;
                    dx   = cols / 2 - c;
                    d_sq = dx * dx + dy * dy;
                    lo   = 4 * longint'(s) * s;
                    hi   = 4 * longint'(s + p) * (s + p);
                    return d_sq >= lo && d_sq < hi;
                end
                default: return 0;
            endcase
        endfunction

        function void advance_tick();
            t_entry      e;
            int unsigned nxt;
            e   = entry_now();
            nxt = pause_cnt + 1;
            if (nxt < e.pause) begin
                pause_cnt = PAUSE_W'(nxt);
                return;
            end
            pause_cnt = 0;
            nxt       = step_cnt + 1;
            if (nxt >= steps_in_pattern()) begin
                if (single_on) begin
                    step_cnt = STEP_W'(nxt);
                    return;
                end
                step_cnt = 0;
                cur_pat  = CUR_W'(cur_pat + 1);
                if (cur_pat >= active_count() && repeat_on) cur_pat = 0;
            end else begin
                step_cnt = STEP_W'(nxt);
            end
        endfunction

        function void write_register(logic [CFG_W-1:0] idx, logic [DIM_W-1:0] val);
            case (idx)
                CFG_ROWS:     rows_reg = val;
                CFG_COLS:     cols_reg = val;
                CFG_COUNT:    count_reg = val[CUR_W-1:0];
                CFG_REPEAT:   repeat_on = val[0];
                CFG_SINGLE: begin
                    single_on = val[0];
                    // entering single mode parks pattern zero at its end
                    if (single_on) begin
                        cur_pat  = 0;
                        step_cnt = STEP_W'(steps_in_pattern());
                    end else begin
                        step_cnt  = 0;
                        pause_cnt = 0;
                    end
                end
                CFG_DRAW_OFF: draw_off_on = val[0];
                default: ;
            endcase
        endfunction

        function void apply_item(t_opcode op, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                 logic [PN_W-1:0] pn, logic [FUNC_W-1:0] fc,
                                 logic [PAUSE_W-1:0] sp, logic [PARAM_W-1:0] pp);
            t_light_result res;
            res.light_on     = 0;
            res.write_enable = 0;
            case (op)
                OP_TICK: begin
                    if (is_running()) advance_tick();
                end
                OP_QUERY: begin
                    if (is_running() && row < bounded_dim(rows_reg) &&
                        col < bounded_dim(cols_reg)) begin
                        res.light_on     = light_is_on(int'(row), int'(col));
                        res.write_enable = res.light_on || draw_off_on;
                    end
                end
                OP_WRITE: begin
                    entries[pn].func  = fc;
                    entries[pn].pause = sp;
                    entries[pn].param = pp;
                end
                OP_FIRE: begin
                    if (pn < active_count()) begin
                        cur_pat   = pn;
                        step_cnt  = 0;
                        pause_cnt = 0;
                    end
                end
                default: ;
            endcase
            res.playing     = is_running();
            res.step        = STEP_W'(step_cnt);
            res.pattern_idx = CUR_W'(cur_pat);
            expected_q.push_back(res);
        endfunction

        function void compare_result(t_light_result seen);
            t_light_result want;
            logic [15:0]   want_f [5];
            logic [15:0]   seen_f [5];
            string         label [5] = '{"light_on", "write_enable", "playing",
                                         "step_number", "pattern_index"};
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing pending: on=%0d we=%0d play=%0d step=%0d pat=%0d",
                         $time, seen.light_on, seen.write_enable, seen.playing,
                         seen.step, seen.pattern_idx);
                errors++;
                return;
            end
            want   = expected_q.pop_front();
            want_f = '{16'(want.light_on), 16'(want.write_enable), 16'(want.playing),
                       16'(want.step), 16'(want.pattern_idx)};
            seen_f = '{16'(seen.light_on), 16'(seen.write_enable), 16'(seen.playing),
                       16'(seen.step), 16'(seen.pattern_idx)};
            foreach (want_f[i]) begin
                if (seen_f[i] !== want_f[i]) begin
                    $display("%0t: %s mismatch: expected %0d, actual %0d",
                             $time, label[i], want_f[i], seen_f[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_W-1:0]   i_cfg_index;
    logic [DIM_W-1:0]   i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_opcode;
    logic [ROW_W-1:0]   i_pixel_row;
    logic [COL_W-1:0]   i_pixel_col;
    logic [PN_W-1:0]    i_pattern_number;
    logic [FUNC_W-1:0]  i_func_code;
    logic [PAUSE_W-1:0] i_step_pause;
    logic [PARAM_W-1:0] i_pattern_param;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_light_on;
    logic               o_write_enable;
    logic               o_playing;
    logic [STEP_W-1:0]  o_step_number;
    logic [CUR_W-1:0]   o_pattern_index;

    light_scoreboard sb = new();
    bit              calm;
    bit              hold_req;
    int              quiet_cycles;

    led_matrix_pattern_sequencer_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_pixel_row      (i_pixel_row),
        .i_pixel_col      (i_pixel_col),
        .i_pattern_number (i_pattern_number),
        .i_func_code      (i_func_code),
        .i_step_pause     (i_step_pause),
        .i_pattern_param  (i_pattern_param),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_light_on       (o_light_on),
        .o_write_enable   (o_write_enable),
        .o_playing        (o_playing),
        .o_step_number    (o_step_number),
        .o_pattern_index  (o_pattern_index)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Track transfers and config writes at the rising edge; watch for a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.compare_result('{light_on: o_light_on, write_enable: o_write_enable,
                                    playing: o_playing, step: o_step_number,
                                    pattern_idx: o_pattern_index});
            end
            if (i_cfg_we) sb.write_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) begin
                sb.apply_item(t_opcode'(i_opcode), i_pixel_row, i_pixel_col,
                              i_pattern_number, i_func_code, i_step_pause, i_pattern_param);
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("led_matrix_pattern_sequencer_core regression: fail");
            $finish;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
    end

    // Result side: random stalls per transfer, one long hold-off on request.
    initial begin
        int gap;
        i_out_stall = 1'b0;
        forever begin
            if (hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            gap = calm ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                i_out_stall = 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
            @(negedge i_clk);
        end
    end

    // Offer one item after a random gap and hold it until the transfer.
    task automatic send_item(t_opcode op, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                             logic [PN_W-1:0] pn, logic [FUNC_W-1:0] fc,
                             logic [PAUSE_W-1:0] sp, logic [PARAM_W-1:0] pp);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode         = op;
        i_pixel_row      = row;
        i_pixel_col      = col;
        i_pattern_number = pn;
        i_func_code      = fc;
        i_step_pause     = sp;
        i_pattern_param  = pp;
        i_in_valid       = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic send_random_item();
        int                 r;
        int                 rdim;
        int                 cdim;
        t_opcode            op;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [PN_W-1:0]    pn;
        logic [FUNC_W-1:0]  fc;
        logic [PAUSE_W-1:0] sp;
        logic [PARAM_W-1:0] pp;
        r    = $urandom_range(0, 99);
        op   = (r < 40) ? OP_QUERY : (r < 84) ? OP_TICK : (r < 92) ? OP_WRITE : OP_FIRE;
        row  = ROW_W'($urandom);
        col  = COL_W'($urandom);
        pn   = PN_W'($urandom);
        fc   = FUNC_W'($urandom);
        sp   = PAUSE_W'($urandom);
        pp   = PARAM_W'($urandom);
        rdim = int'(sb.bounded_dim(sb.rows_reg));
        cdim = int'(sb.bounded_dim(sb.cols_reg));
        // mostly aim queries inside the area
        if (op == OP_QUERY && $urandom_range(0, 4) != 0) begin
            row = ROW_W'($urandom_range(0, rdim - 1));
            col = COL_W'($urandom_range(0, cdim - 1));
        end
        if (op == OP_WRITE) begin
            r = $urandom_range(0, 23);
            if (r <= int'(FN_DIAG)) begin
                fc = FUNC_W'(r);
            end else if (r < 21) begin
                fc = FN_RING;
            end
            r = $urandom_range(0, 9);
            if (r < 7) begin
                sp = PAUSE_W'($urandom_range(0, 3));
            end else if (r < 9) begin
                sp = PAUSE_W'($urandom_range(0, 20));
            end
            if (fc == FN_DIAG) begin
                pp = PARAM_W'($urandom_range(0, 5));
            end else if ($urandom_range(0, 2) != 0) begin
                pp = PARAM_W'($urandom_range(1, 8));
            end
        end
        send_item(op, row, col, pn, fc, sp, pp);
    endtask

    task automatic set_register(logic [CFG_W-1:0] idx, int unsigned val);
        i_cfg_index = idx;
        i_cfg_data  = DIM_W'(val);
        i_cfg_we    = 1'b1;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    function automatic int unsigned pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return MAX_DIM;
        if (r == 2) return $urandom_range(MAX_DIM + 1, 127);
        return $urandom_range(1, 8);
    endfunction

    initial begin
        int unsigned rows_v;
        int unsigned cols_v;
        int unsigned count_v;
        int unsigned rep_v;
        int unsigned single_v;
        int unsigned draw_v;
        int          r;
        logic [FUNC_W-1:0] fc;

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_ROWS;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_opcode         = OP_TICK;
        i_pixel_row      = '0;
        i_pixel_col      = '0;
        i_pattern_number = '0;
        i_func_code      = '0;
        i_step_pause     = '0;
        i_pattern_param  = '0;
        calm             = 1'b0;
        hold_req         = 1'b0;
        quiet_cycles     = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill the whole table first so that no unwritten entry is ever read.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i == 0) begin
                fc = FN_RING;
            end else if (i == TABLE_DEPTH - 1) begin
                fc = FN_DIAG;
            end else begin
                fc = FUNC_W'(i);
            end
            send_item(OP_WRITE, ROW_W'($urandom), COL_W'($urandom), PN_W'(i), fc,
                      (i == 9) ? '1 : '0,
                      (i == TABLE_DEPTH - 1) ? DIAG_NW : (i == 6) ? '1 : PARAM_W'(2));
        end
        // Nothing plays with an empty count: tick, far corner, fire out of range.
        send_item(OP_TICK, '1, '1, '1, '1, '1, '1);
        send_item(OP_QUERY, '1, '1, '0, '0, '0, '0);
        send_item(OP_FIRE, '0, '0, '1, '0, '0, '0);
        send_item(OP_QUERY, '0, '0, '0, '1, '1, '1);

        for (int ph = 0; ph < PHASES; ph++) begin
            i_in_valid = 1'b0;
            while (sb.expected_q.size() != 0) @(negedge i_clk);
            repeat (DRAIN_CYCLES) @(negedge i_clk);
            case (ph)
                0: begin
                    rows_v = 1; cols_v = 1; count_v = TABLE_DEPTH;
                    rep_v = 1; single_v = 0; draw_v = 0;
                end
                1: begin
                    rows_v = MAX_DIM; cols_v = MAX_DIM; count_v = TABLE_DEPTH;
                    rep_v = 0; single_v = 1; draw_v = 1;
                end
                2: begin
                    rows_v = 0; cols_v = 127; count_v = 31;
                    rep_v = 1; single_v = 0; draw_v = 1;
                end
                default: begin
                    rows_v = pick_dim();
                    cols_v = pick_dim();
                    r      = $urandom_range(0, 9);
                    if (r == 0) begin
                        count_v = 0;
                    end else if (r == 1) begin
                        count_v = TABLE_DEPTH;
                    end else if (r == 2) begin
                        count_v = $urandom_range(TABLE_DEPTH + 1, 31);
                    end else begin
                        count_v = $urandom_range(1, TABLE_DEPTH - 1);
                    end
                    rep_v    = $urandom_range(0, 1);
                    single_v = $urandom_range(0, 1);
                    draw_v   = $urandom_range(0, 1);
                end
            endcase
            set_register(CFG_ROWS, rows_v);
            set_register(CFG_COLS, cols_v);
            set_register(CFG_COUNT, count_v);
            set_register(CFG_REPEAT, rep_v);
            set_register(CFG_SINGLE, single_v);
            set_register(CFG_DRAW_OFF, draw_v);
            calm = (ph % 4 == 3);
            if (ph == 4) hold_req = 1'b1;
            // start each phase with a nonzero count from a live pattern
            if (sb.active_count() > 0) begin
                send_item(OP_FIRE, ROW_W'($urandom), COL_W'($urandom),
                          PN_W'($urandom_range(0, sb.active_count() - 1)),
                          FUNC_W'($urandom), PAUSE_W'($urandom), PARAM_W'($urandom));
            end
            repeat (PHASE_ITEMS) send_random_item();
        end

        i_in_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("led_matrix_pattern_sequencer_core regression: pass");
        end else begin
            $display("led_matrix_pattern_sequencer_core regression: fail");
        end
        $finish;
    end
endmodule
